@@ rtl/pedda_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pedda_pkg: shared types and constants of the polygon edge walker
// Coordinate widths, word formats and the operation codes of the shared
// arithmetic unit.
// ============================================================================
package pedda_pkg;

    // Coordinate width, and the width of the signed duty term.
    localparam int COORD_BITS = 10;
    localparam int DUTY_BITS  = COORD_BITS + 2;

    // Action codes of an input word.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD     = 2'd0,
        ALU_SUB     = 2'd1,
        ALU_ABSDIFF = 2'd2
    } alu_op_t;

    // Input word: a load or a step command.
    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } in_word_t;

    // Result word: edge x on one scanline.
    typedef struct packed {
        logic [COORD_BITS-1:0] edge_x;
        logic                  last_line;
    } out_word_t;

endpackage

@@ rtl/pedda_alu.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pedda_alu: shared add, subtract and absolute-difference unit
// One adder with an operand swap driven by a signed compare. The sequencer
// reuses it for the load setup and for every duty term update.
// ============================================================================
module pedda_alu (
    input  pedda_pkg::alu_op_t                     op,
    input  logic signed [pedda_pkg::DUTY_BITS-1:0] opa,
    input  logic signed [pedda_pkg::DUTY_BITS-1:0] opb,
    output logic signed [pedda_pkg::DUTY_BITS-1:0] result,
    output logic                                   a_lt_b
);
    import pedda_pkg::*;

    logic                        swap;
    logic signed [DUTY_BITS-1:0] lhs;
    logic signed [DUTY_BITS-1:0] rhs;

    // The compare picks the operand order so that an absolute difference
    // needs only one subtraction.
    assign a_lt_b = (opa < opb);
    assign swap   = (op == ALU_ABSDIFF) && a_lt_b;
    assign lhs    = swap ? opb : opa;
    assign rhs    = swap ? opa : opb;

    // Single adder; subtraction for everything but ADD.
    always_comb begin
        case (op)
            ALU_ADD: result = lhs + rhs;
            default: result = lhs - rhs;
        endcase
    end

endmodule

@@ rtl/polygon_edge_dda_unit.sv @@
`timescale 1ns / 1ps
// Load word: accepted, then set up on the shared unit in LD_DX, LD_DY, LD_DUTY.
// Step word: each walk step updates the duty term and moves x one pixel while
// it was positive; then the emit state writes the result register when free.
// One word is in work at a time; the shared adder sets the pace of the walk.
// Synchronous active-low reset clears the edge state: no edge is loaded.
// ============================================================================
// polygon_edge_dda_unit: Bresenham edge walker for scan conversion
// Load words set up an edge from its two endpoints; each step word gives the
// edge x on the next scanline, flagged on the last; later ones give no result.
// ============================================================================
module polygon_edge_dda_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pedda_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pedda_pkg::out_word_t m_data
);
    import pedda_pkg::*;

    localparam int EXT_BITS = DUTY_BITS - COORD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_LD_DX   = 6'b000010,
        ST_LD_DY   = 6'b000100,
        ST_LD_DUTY = 6'b001000,
        ST_WALK    = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    in_word_t                    in_reg, in_next;
    logic [COORD_BITS-1:0]       cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]       abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0]       abs_dy_reg, abs_dy_next;
    logic                        step_left_reg, step_left_next;
    logic signed [DUTY_BITS-1:0] duty_reg, duty_next;
    logic [COORD_BITS-1:0]       lines_left_reg, lines_left_next;
    logic                        m_valid_reg, m_valid_next;
    out_word_t                   m_data_reg, m_data_next;

    alu_op_t                     alu_op;
    logic signed [DUTY_BITS-1:0] alu_a;
    logic signed [DUTY_BITS-1:0] alu_b;
    logic signed [DUTY_BITS-1:0] alu_res;
    logic                        alu_lt;
    logic                        duty_pos;
    logic                        s_fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign duty_pos = !duty_reg[DUTY_BITS-1] && (duty_reg != '0);

    // Shared arithmetic unit.
    pedda_alu u_alu (
        .op     (alu_op),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_res),
        .a_lt_b (alu_lt)
    );

    // Operand selection for the shared unit, by sequencer state.
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = duty_reg;
        alu_b  = signed'({{EXT_BITS{1'b0}}, abs_dy_reg});
        unique case (state_reg)
            ST_LD_DX: begin
                alu_op = ALU_ABSDIFF;
                alu_a  = signed'({{EXT_BITS{1'b0}}, in_reg.x_end});
                alu_b  = signed'({{EXT_BITS{1'b0}}, in_reg.x_start});
            end
            ST_LD_DY: begin
                alu_op = ALU_ABSDIFF;
                alu_a  = signed'({{EXT_BITS{1'b0}}, in_reg.y_end});
                alu_b  = signed'({{EXT_BITS{1'b0}}, in_reg.y_start});
            end
            ST_LD_DUTY: begin
                alu_op = ALU_SUB;
                alu_a  = signed'({{EXT_BITS{1'b0}}, abs_dx_reg});
                alu_b  = signed'({{(EXT_BITS+1){1'b0}}, abs_dy_reg[COORD_BITS-1:1]});
            end
            ST_WALK: begin
                if (duty_pos && (abs_dy_reg != '0)) begin
                    alu_op = ALU_SUB;
                    alu_b  = signed'({{EXT_BITS{1'b0}}, abs_dy_reg});
                end else begin
                    alu_op = ALU_ADD;
                    alu_b  = signed'({{EXT_BITS{1'b0}}, abs_dx_reg});
                end
            end
            default: begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // Sequencer and edge state update.
    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        cur_x_next      = cur_x_reg;
        abs_dx_next     = abs_dx_reg;
        abs_dy_next     = abs_dy_reg;
        step_left_next  = step_left_reg;
        duty_next       = duty_reg;
        lines_left_next = lines_left_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    in_next = s_data;
                    if (s_data.action == ACT_LOAD) begin
                        state_next = ST_LD_DX;
                    end else if (lines_left_reg != '0) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_LD_DX: begin
                abs_dx_next    = alu_res[COORD_BITS-1:0];
                step_left_next = alu_lt;
                cur_x_next     = in_reg.x_start;
                state_next     = ST_LD_DY;
            end
            ST_LD_DY: begin
                abs_dy_next     = alu_res[COORD_BITS-1:0];
                lines_left_next = alu_res[COORD_BITS-1:0];
                state_next      = ST_LD_DUTY;
            end
            ST_LD_DUTY: begin
                duty_next  = alu_res;
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                // Move one pixel per cycle while the duty term is positive.
                duty_next = alu_res;
                if (duty_pos && (abs_dy_reg != '0)) begin
                    cur_x_next = step_left_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
                end else begin
                    lines_left_next = lines_left_reg - 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Wait for the result register to be free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.edge_x    = cur_x_reg;
                    m_data_next.last_line = (lines_left_reg == '0);
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            cur_x_reg      <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            step_left_reg  <= 1'b0;
            duty_reg       <= '0;
            lines_left_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            cur_x_reg      <= cur_x_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            step_left_reg  <= step_left_next;
            duty_reg       <= duty_next;
            lines_left_reg <= lines_left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

endmodule
